>>> rtl/core/dafm_pkg.sv
// Shared constants, types and register codes for the DRAM address field mapper.
// No dependencies; every other file of the block imports this package.
package dafm_pkg;

  localparam int FIELD_COUNT  = 6;
  localparam int ADDR_WIDTH   = 64;
  localparam int PHYS_WIDTH   = 64;
  localparam int FIELD_WIDTH  = 32;
  localparam int WIDTH_BITS   = 6;
  localparam int POS_BITS     = 3;
  localparam int BURST_BITS   = 4;
  localparam int ORDER_BITS   = FIELD_COUNT * POS_BITS;
  localparam int SHIFT_BITS   = $clog2(PHYS_WIDTH);
  localparam int MAX_OFFSET   = (2 ** BURST_BITS - 1) + (FIELD_COUNT - 1) * (2 ** WIDTH_BITS - 1);
  localparam int OFF_BITS     = $clog2(MAX_OFFSET + 1);
  localparam int REG_COUNT    = FIELD_COUNT + 2;
  localparam int REG_IDX_BITS = $clog2(REG_COUNT);
  localparam int PADDR_BITS   = REG_IDX_BITS + 2;
  localparam int DATA_BITS    = 32;

  localparam logic [PHYS_WIDTH-1:0] ADDR_MASK = {PHYS_WIDTH{1'b1}} >> (PHYS_WIDTH - ADDR_WIDTH);

  localparam logic [REG_IDX_BITS-1:0] REG_FIELD_ORDER = REG_IDX_BITS'(FIELD_COUNT);
  localparam logic [REG_IDX_BITS-1:0] REG_BURST       = REG_IDX_BITS'(FIELD_COUNT + 1);

  typedef logic [FIELD_COUNT-1:0][WIDTH_BITS-1:0]  width_vec_t;
  typedef logic [FIELD_COUNT-1:0][FIELD_WIDTH-1:0] field_vec_t;
  typedef logic [FIELD_COUNT-1:0][OFF_BITS-1:0]    off_vec_t;
  typedef logic [FIELD_COUNT-1:0][PHYS_WIDTH-1:0]  term_vec_t;

  localparam width_vec_t WIDTH_RESET = {6'd0, 6'd1, 6'd1, 6'd3, 6'd10, 6'd16};
  localparam logic [ORDER_BITS-1:0] ORDER_RESET = 18'd144453;
  localparam logic [BURST_BITS-1:0] BURST_RESET = 4'd6;

  typedef enum logic {
    CMD_DECODE = 1'b0,
    CMD_ENCODE = 1'b1
  } cmd_t;

  typedef struct packed {
    width_vec_t              width;
    logic [ORDER_BITS-1:0]   order;
    logic [BURST_BITS-1:0]   burst;
  } cfg_t;

  typedef struct packed {
    cmd_t                    cmd;
    logic [PHYS_WIDTH-1:0]   addr;
    field_vec_t              value;
    logic [FIELD_COUNT-1:0]  win;
    off_vec_t                off;
    width_vec_t              width;
  } plan_t;

  typedef struct packed {
    field_vec_t              field;
    term_vec_t               term;
  } shift_t;

endpackage

>>> rtl/core/dafm_cfg.sv
// Configuration register file of the address field mapper, on an APB-style port.
// Depends on dafm_pkg for register codes, reset values and the cfg_t bundle.
module dafm_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [dafm_pkg::PADDR_BITS-1:0]    paddr,
  input  logic [dafm_pkg::DATA_BITS-1:0]     pwdata,
  output logic [dafm_pkg::DATA_BITS-1:0]     prdata,
  output logic                               pready,
  output dafm_pkg::cfg_t                     cfg
);
  import dafm_pkg::*;

  width_vec_t              width_r;
  logic [ORDER_BITS-1:0]   order_r;
  logic [BURST_BITS-1:0]   burst_r;
  logic [REG_IDX_BITS-1:0] idx;
  logic                    wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[PADDR_BITS-1:2];
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= WIDTH_RESET;
      order_r <= ORDER_RESET;
      burst_r <= BURST_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_FIELD_ORDER: order_r <= pwdata[ORDER_BITS-1:0];
        REG_BURST:       burst_r <= pwdata[BURST_BITS-1:0];
        default:         width_r[idx] <= pwdata[WIDTH_BITS-1:0];
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FIELD_ORDER: prdata = DATA_BITS'(order_r);
      REG_BURST:       prdata = DATA_BITS'(burst_r);
      default:         prdata = DATA_BITS'(width_r[idx]);
    endcase
  end

  assign cfg.width = width_r;
  assign cfg.order = order_r;
  assign cfg.burst = burst_r;

endmodule

>>> rtl/core/dafm_plan.sv
// First pipeline stage: resolves which field owns each position and each field's bit offset.
// Depends on dafm_pkg for the cfg_t and plan_t types.
module dafm_plan (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    command,
  input  logic [63:0]             phys_address,
  input  dafm_pkg::field_vec_t    value,
  input  dafm_pkg::cfg_t          cfg,
  output logic                    s1_valid,
  output dafm_pkg::plan_t         s1,
  input  logic                    s1_stall
);
  import dafm_pkg::*;

  logic [FIELD_COUNT-1:0][POS_BITS-1:0] pos;
  logic [FIELD_COUNT-1:0]               win;
  off_vec_t                             off;
  logic                                 valid_r;
  plan_t                                data_r;
  logic                                 advance;

  always_comb begin
    for (int f = 0; f < FIELD_COUNT; f++) begin
      pos[f] = cfg.order[f*POS_BITS +: POS_BITS];
    end
  end

  // A field is used only if its position is in range and no earlier field claims it.
  always_comb begin
    for (int f = 0; f < FIELD_COUNT; f++) begin
      win[f] = (pos[f] < POS_BITS'(FIELD_COUNT));
      for (int g = 0; g < f; g++) begin
        if (pos[g] == pos[f]) begin
          win[f] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    for (int f = 0; f < FIELD_COUNT; f++) begin
      off[f] = OFF_BITS'(cfg.burst);
      for (int g = 0; g < FIELD_COUNT; g++) begin
        if (win[g] && (pos[g] < pos[f])) begin
          off[f] = off[f] + OFF_BITS'(cfg.width[g]);
        end
      end
    end
  end

  assign advance  = !valid_r || !s1_stall;
  assign in_stall = !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      data_r.cmd   <= cmd_t'(command);
      data_r.addr  <= phys_address & ADDR_MASK;
      data_r.value <= value;
      data_r.win   <= win;
      data_r.off   <= off;
      data_r.width <= cfg.width;
    end
  end

  assign s1_valid = valid_r;
  assign s1       = data_r;

endmodule

>>> rtl/core/dafm_shift.sv
// Second pipeline stage: one barrel shift per field, right for decode and left for encode.
// Depends on dafm_pkg for the plan_t and shift_t types.
module dafm_shift (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                s1_valid,
  input  dafm_pkg::plan_t     s1,
  output logic                s1_stall,
  output logic                s2_valid,
  output dafm_pkg::shift_t    s2,
  input  logic                s2_stall
);
  import dafm_pkg::*;

  term_vec_t  shr;
  field_vec_t fld;
  term_vec_t  term;
  logic       valid_r;
  shift_t     data_r;
  logic       advance;

  function automatic logic [FIELD_WIDTH-1:0] field_mask(input logic [WIDTH_BITS-1:0] w);
    logic [FIELD_WIDTH-1:0] m;
    m = '1;
    if (w < WIDTH_BITS'(FIELD_WIDTH)) begin
      m = ~({FIELD_WIDTH{1'b1}} << w);
    end
    return m;
  endfunction

  always_comb begin
    for (int f = 0; f < FIELD_COUNT; f++) begin
      shr[f]  = s1.addr >> s1.off[f][SHIFT_BITS-1:0];
      fld[f]  = '0;
      term[f] = '0;
      if (s1.win[f] && (s1.off[f] < OFF_BITS'(PHYS_WIDTH))) begin
        if (s1.cmd == CMD_DECODE) begin
          fld[f] = shr[f][FIELD_WIDTH-1:0] & field_mask(s1.width[f]);
        end else begin
          term[f] = PHYS_WIDTH'(s1.value[f]) << s1.off[f][SHIFT_BITS-1:0];
        end
      end
    end
  end

  assign advance  = !valid_r || !s2_stall;
  assign s1_stall = !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      data_r.field <= fld;
      data_r.term  <= term;
    end
  end

  assign s2_valid = valid_r;
  assign s2       = data_r;

endmodule

>>> rtl/core/dafm_sum.sv
// Third and fourth pipeline stages: adds the six encode terms in a two-level registered tree.
// Depends on dafm_pkg for the shift_t type; the last stage is the output register.
module dafm_sum (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          s2_valid,
  input  dafm_pkg::shift_t              s2,
  output logic                          s2_stall,
  output logic                          out_valid,
  output dafm_pkg::field_vec_t          field,
  output logic [dafm_pkg::PHYS_WIDTH-1:0] encoded,
  input  logic                          out_stall
);
  import dafm_pkg::*;

  localparam int PAIR_COUNT = FIELD_COUNT / 2;

  logic                                  v3_r;
  logic [PAIR_COUNT-1:0][PHYS_WIDTH-1:0] pair_r;
  field_vec_t                            field3_r;
  logic                                  v4_r;
  field_vec_t                            field4_r;
  logic [PHYS_WIDTH-1:0]                 enc_r;
  logic [PHYS_WIDTH-1:0]                 enc_nxt;
  logic                                  adv3;
  logic                                  adv4;

  assign adv4     = !v4_r || !out_stall;
  assign adv3     = !v3_r || adv4;
  assign s2_stall = !adv3;

  always_comb begin
    enc_nxt = '0;
    for (int p = 0; p < PAIR_COUNT; p++) begin
      enc_nxt = enc_nxt + pair_r[p];
    end
    enc_nxt = enc_nxt & ADDR_MASK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (adv3) begin
        v3_r <= s2_valid;
      end
      if (adv4) begin
        v4_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && s2_valid) begin
      for (int p = 0; p < PAIR_COUNT; p++) begin
        pair_r[p] <= s2.term[2*p] + s2.term[2*p+1];
      end
      field3_r <= s2.field;
    end
    if (adv4 && v3_r) begin
      enc_r    <= enc_nxt;
      field4_r <= field3_r;
    end
  end

  assign out_valid = v4_r;
  assign field     = field4_r;
  assign encoded   = enc_r;

endmodule

>>> rtl/core/dram_address_field_mapper.sv
// Top level of the DRAM address field mapper: config registers and a four-stage pipeline.
// One item per cycle is sustained while out_stall stays low.
// The stages are offset planning, per-field barrel shift, pair adds and final add.
// Synchronous active-low reset empties the pipeline and loads the default field layout.
// Depends on dafm_pkg, dafm_cfg, dafm_plan, dafm_shift and dafm_sum.
module dram_address_field_mapper (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [dafm_pkg::PADDR_BITS-1:0]  paddr,
  input  logic [dafm_pkg::DATA_BITS-1:0]   pwdata,
  output logic [dafm_pkg::DATA_BITS-1:0]   prdata,
  output logic                             pready,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_command,
  input  logic [63:0]                      in_phys_address,
  input  logic [31:0]                      in_row_in,
  input  logic [31:0]                      in_col_in,
  input  logic [31:0]                      in_bank_in,
  input  logic [31:0]                      in_rank_in,
  input  logic [31:0]                      in_channel_in,
  input  logic [31:0]                      in_subarray_in,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [31:0]                      out_row_out,
  output logic [31:0]                      out_col_out,
  output logic [31:0]                      out_bank_out,
  output logic [31:0]                      out_rank_out,
  output logic [31:0]                      out_channel_out,
  output logic [31:0]                      out_subarray_out,
  output logic [63:0]                      out_encoded_address
);
  import dafm_pkg::*;

  cfg_t       cfg;
  field_vec_t value;
  logic       s1_valid;
  logic       s1_stall;
  plan_t      s1;
  logic       s2_valid;
  logic       s2_stall;
  shift_t     s2;
  field_vec_t field;

  assign value = {in_subarray_in, in_channel_in, in_rank_in, in_bank_in, in_col_in, in_row_in};

  dafm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dafm_plan u_plan (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (in_command),
    .phys_address (in_phys_address),
    .value        (value),
    .cfg          (cfg),
    .s1_valid     (s1_valid),
    .s1           (s1),
    .s1_stall     (s1_stall)
  );

  dafm_shift u_shift (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1       (s1),
    .s1_stall (s1_stall),
    .s2_valid (s2_valid),
    .s2       (s2),
    .s2_stall (s2_stall)
  );

  dafm_sum u_sum (
    .clk       (clk),
    .rst_n     (rst_n),
    .s2_valid  (s2_valid),
    .s2        (s2),
    .s2_stall  (s2_stall),
    .out_valid (out_valid),
    .field     (field),
    .encoded   (out_encoded_address),
    .out_stall (out_stall)
  );

  assign out_row_out      = field[0];
  assign out_col_out      = field[1];
  assign out_bank_out     = field[2];
  assign out_rank_out     = field[3];
  assign out_channel_out  = field[4];
  assign out_subarray_out = field[5];

endmodule

>>> rtl/core/dafm_checker.sv
// Port-level checker for the DRAM address field mapper, bound to the top level.
// Imports dafm_pkg; its ports have fixed widths.
module dafm_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [31:0]                      out_row_out,
  input logic [31:0]                      out_col_out,
  input logic [31:0]                      out_bank_out,
  input logic [31:0]                      out_rank_out,
  input logic [31:0]                      out_channel_out,
  input logic [31:0]                      out_subarray_out,
  input logic [63:0]                      out_encoded_address
);
  import dafm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("Result item dropped while stalled.");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_encoded_address) && $stable(out_row_out))
    else $error("Result item changed while stalled.");

  a_encode_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_encoded_address != 64'd0) |->
      (out_row_out == 32'd0) && (out_col_out == 32'd0) && (out_bank_out == 32'd0) &&
      (out_rank_out == 32'd0) && (out_channel_out == 32'd0) && (out_subarray_out == 32'd0))
    else $error("Encode item carries nonzero field outputs.");

  a_empty_output_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("Input stalled while the output register is empty.");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall |=> out_valid)
    else $error("Item did not reach the output after four free cycles.");

endmodule

bind dram_address_field_mapper dafm_checker u_dafm_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_row_out         (out_row_out),
  .out_col_out         (out_col_out),
  .out_bank_out        (out_bank_out),
  .out_rank_out        (out_rank_out),
  .out_channel_out     (out_channel_out),
  .out_subarray_out    (out_subarray_out),
  .out_encoded_address (out_encoded_address)
);

>>> test/tb_mapper_checker.sv
// Checker for the DRAM address field mapper: tracks the register writes, predicts each item's
// result and compares it with what the block delivers. Depends on dafm_pkg only.
module tb_mapper_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [dafm_pkg::PADDR_BITS-1:0] paddr,
  input  logic [dafm_pkg::DATA_BITS-1:0]  pwdata,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic                           in_command,
  input  logic [63:0]                    in_phys_address,
  input  logic [31:0]                    in_row_in,
  input  logic [31:0]                    in_col_in,
  input  logic [31:0]                    in_bank_in,
  input  logic [31:0]                    in_rank_in,
  input  logic [31:0]                    in_channel_in,
  input  logic [31:0]                    in_subarray_in,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [31:0]                    out_row_out,
  input  logic [31:0]                    out_col_out,
  input  logic [31:0]                    out_bank_out,
  input  logic [31:0]                    out_rank_out,
  input  logic [31:0]                    out_channel_out,
  input  logic [31:0]                    out_subarray_out,
  input  logic [63:0]                    out_encoded_address,
  output int                             mismatch_count,
  output int                             pending_items
);
  timeunit 1ns;
  timeprecision 1ps;
  import dafm_pkg::*;

  typedef struct packed {
    field_vec_t  fld;
    logic [63:0] enc;
  } mapping_t;

  logic [WIDTH_BITS-1:0] field_bits [FIELD_COUNT];
  logic [ORDER_BITS-1:0] layout_order;
  logic [BURST_BITS-1:0] burst_shift;
  mapping_t              mapping_q[$];
  int                    err_total = 0;
  int                    queued = 0;
  string                 field_name [FIELD_COUNT] =
    '{"row", "col", "bank", "rank", "channel", "subarray"};

  assign mismatch_count = err_total;
  assign pending_items  = queued;

  function automatic int field_at(int pos);
    for (int f = 0; f < FIELD_COUNT; f++) begin
      if (layout_order[POS_BITS*f +: POS_BITS] == pos) return f;
    end
    return -1;
  endfunction

  function automatic mapping_t map_request(cmd_t cmd, logic [63:0] addr, field_vec_t vals);
    mapping_t    r;
    logic [63:0] rest;
    int          off;
    int          f;
    r = '0;
    if (cmd == CMD_DECODE) begin
      rest = (addr & ADDR_MASK) >> burst_shift;
      for (int pos = 0; pos < FIELD_COUNT; pos++) begin
        f = field_at(pos);
        if (f >= 0) begin
          r.fld[f] = 32'(rest & ((64'd1 << field_bits[f]) - 64'd1));
          rest = rest >> field_bits[f];
        end
      end
    end else begin
      off = burst_shift;
      for (int pos = 0; pos < FIELD_COUNT; pos++) begin
        f = field_at(pos);
        if (f >= 0) begin
          if (off < 64) r.enc = r.enc + ({32'd0, vals[f]} << off);
          off += field_bits[f];
        end
      end
      r.enc = r.enc & ADDR_MASK;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    logic [REG_IDX_BITS-1:0] idx;
    field_vec_t              vals;
    field_vec_t              got;
    mapping_t                want;
    if (!rst_n) begin
      for (int f = 0; f < FIELD_COUNT; f++) field_bits[f] = WIDTH_RESET[f];
      layout_order = ORDER_RESET;
      burst_shift  = BURST_RESET;
      mapping_q.delete();
      queued = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        idx = paddr[PADDR_BITS-1:2];
        if (idx < FIELD_COUNT) field_bits[idx] = pwdata[WIDTH_BITS-1:0];
        else if (idx == REG_FIELD_ORDER) layout_order = pwdata[ORDER_BITS-1:0];
        else if (idx == REG_BURST) burst_shift = pwdata[BURST_BITS-1:0];
      end
      if (in_valid && !in_stall) begin
        vals = {in_subarray_in, in_channel_in, in_rank_in, in_bank_in, in_col_in, in_row_in};
        mapping_q.push_back(map_request(cmd_t'(in_command), in_phys_address, vals));
      end
      if (out_valid && !out_stall) begin
        got = {out_subarray_out, out_channel_out, out_rank_out, out_bank_out, out_col_out,
               out_row_out};
        if (mapping_q.size() == 0) begin
          $display("%0t: result with no item pending: expected none, actual fields %h addr %h",
                   $time, got, out_encoded_address);
          err_total++;
        end else begin
          want = mapping_q.pop_front();
          for (int f = 0; f < FIELD_COUNT; f++) begin
            if (got[f] !== want.fld[f]) begin
              $display("%0t: %s mismatch: expected %h, actual %h", $time, field_name[f],
                       want.fld[f], got[f]);
              err_total++;
            end
          end
          if (out_encoded_address !== want.enc) begin
            $display("%0t: encoded address mismatch: expected %h, actual %h", $time,
                     want.enc, out_encoded_address);
            err_total++;
          end
        end
      end
      queued = mapping_q.size();
    end
  end

endmodule

>>> test/tb_top.sv
// Testbench top for the DRAM address field mapper: clock, reset, register writes and items.
// Uses dafm_pkg, the block under test and tb_mapper_checker, which checks each result.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dafm_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  psel, penable, pwrite;
  logic [PADDR_BITS-1:0] paddr;
  logic [DATA_BITS-1:0]  pwdata;
  logic [DATA_BITS-1:0]  prdata;
  logic                  pready;
  logic                  in_valid, in_stall, in_command;
  logic [63:0]           in_phys_address;
  logic [31:0]           in_row_in, in_col_in, in_bank_in, in_rank_in;
  logic [31:0]           in_channel_in, in_subarray_in;
  logic                  out_valid, out_stall;
  logic [31:0]           out_row_out, out_col_out, out_bank_out, out_rank_out;
  logic [31:0]           out_channel_out, out_subarray_out;
  logic [63:0]           out_encoded_address;
  int                    mismatch_count, pending_items;
  int                    send_idle_pct = 0;
  int                    recv_stall_pct = 0;
  bit                    hold_req = 1'b0;

  always #5 clk = ~clk;

  dram_address_field_mapper u_top (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .in_command, .in_phys_address, .in_row_in, .in_col_in,
    .in_bank_in, .in_rank_in, .in_channel_in, .in_subarray_in,
    .out_valid, .out_stall, .out_row_out, .out_col_out, .out_bank_out, .out_rank_out,
    .out_channel_out, .out_subarray_out, .out_encoded_address
  );

  tb_mapper_checker u_checker (
    .clk, .rst_n, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .in_valid, .in_stall, .in_command, .in_phys_address, .in_row_in, .in_col_in,
    .in_bank_in, .in_rank_in, .in_channel_in, .in_subarray_in,
    .out_valid, .out_stall, .out_row_out, .out_col_out, .out_bank_out, .out_rank_out,
    .out_channel_out, .out_subarray_out, .out_encoded_address,
    .mismatch_count, .pending_items
  );

  // The receiver normally stalls at random; on request it holds off for a long stretch.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (60) @(posedge clk);
        hold_req = 1'b0;
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx,
                           input logic [DATA_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_layout(input width_vec_t widths, input logic [ORDER_BITS-1:0] order,
                             input logic [BURST_BITS-1:0] burst);
    for (int f = 0; f < FIELD_COUNT; f++) write_reg(REG_IDX_BITS'(f), DATA_BITS'(widths[f]));
    write_reg(REG_FIELD_ORDER, DATA_BITS'(order));
    write_reg(REG_BURST, DATA_BITS'(burst));
  endtask

  task automatic random_layout();
    width_vec_t            widths;
    logic [ORDER_BITS-1:0] order;
    int                    perm [FIELD_COUNT];
    int                    j, tmp;
    for (int f = 0; f < FIELD_COUNT; f++) begin
      widths[f] = ($urandom_range(9) == 0) ? WIDTH_BITS'($urandom_range(33, 63))
                                           : WIDTH_BITS'($urandom_range(0, 32));
      perm[f] = f;
    end
    if ($urandom_range(3) == 0) begin
      order = ORDER_BITS'($urandom);
    end else begin
      for (int f = FIELD_COUNT - 1; f > 0; f--) begin
        j = $urandom_range(f);
        tmp = perm[f];
        perm[f] = perm[j];
        perm[j] = tmp;
      end
      order = '0;
      for (int f = 0; f < FIELD_COUNT; f++) order[POS_BITS*f +: POS_BITS] = POS_BITS'(perm[f]);
    end
    load_layout(widths, order, ($urandom_range(7) == 0) ? BURST_BITS'($urandom_range(13, 15))
                                                        : BURST_BITS'($urandom_range(0, 12)));
  endtask

  task automatic send_item(input cmd_t cmd, input logic [63:0] addr, input field_vec_t vals);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_phys_address <= addr;
    in_row_in       <= vals[0];
    in_col_in       <= vals[1];
    in_bank_in      <= vals[2];
    in_rank_in      <= vals[3];
    in_channel_in   <= vals[4];
    in_subarray_in  <= vals[5];
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random();
    field_vec_t vals;
    for (int f = 0; f < FIELD_COUNT; f++) begin
      vals[f] = $urandom;
      if ($urandom_range(1)) vals[f] = vals[f] >> $urandom_range(31);
    end
    send_item(cmd_t'($urandom_range(1)), {$urandom, $urandom}, vals);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_items != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic directed_items();
    send_item(CMD_DECODE, 64'd0, '0);
    send_item(CMD_DECODE, '1, '0);
    send_item(CMD_DECODE, 64'hA5A5_5A5A_C3C3_3C3C, '0);
    send_item(CMD_ENCODE, '1, '1);
    send_item(CMD_ENCODE, 64'd0, {FIELD_COUNT{32'h5555_AAAA}});
    drain();
  endtask

  initial begin
    rst_n           <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    in_valid        <= 1'b0;
    in_command      <= CMD_DECODE;
    in_phys_address <= '0;
    in_row_in       <= '0;
    in_col_in       <= '0;
    in_bank_in      <= '0;
    in_rank_in      <= '0;
    in_channel_in   <= '0;
    in_subarray_in  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default layout, then empty fields, widest fields with the largest burst offset,
    // every field on one position, and a layout with unclaimed and unused positions.
    directed_items();
    load_layout('0, 18'o543210, 4'd0);
    directed_items();
    load_layout({FIELD_COUNT{6'd63}}, 18'o012345, 4'd15);
    directed_items();
    load_layout({FIELD_COUNT{6'd32}}, 18'o000000, 4'd12);
    directed_items();
    load_layout({6'd5, 6'd7, 6'd9, 6'd11, 6'd13, 6'd17}, 18'o310067, 4'd3);
    directed_items();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct  = (phase == 0) ? 38 : (phase == 1) ? 50 : 0;
      recv_stall_pct = (phase == 0) ? 50 : (phase == 1) ? 38 : 0;
      for (int blk = 0; blk < 4; blk++) begin
        drain();
        random_layout();
        for (int i = 0; i < 48; i++) begin
          if (phase == 0 && blk == 1 && i == 10) hold_req = 1'b1;
          if (phase == 1 && blk == 2 && i == 25) drain();
          send_random();
        end
      end
    end

    in_valid <= 1'b0;
    for (int n = 0; n < 2000 && pending_items != 0; n++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_items == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> files.f
rtl/core/dafm_pkg.sv
rtl/core/dafm_cfg.sv
rtl/core/dafm_plan.sv
rtl/core/dafm_shift.sv
rtl/core/dafm_sum.sv
rtl/core/dram_address_field_mapper.sv
rtl/core/dafm_checker.sv
test/tb_mapper_checker.sv
test/tb_top.sv
